// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; each checks on the rising clock edge
// and is quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GNKR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define GNKR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: design/gnkr_pkg.sv
// ----------------------------------------------------------------------------
// gnkr_pkg
// Types, codes and helper functions of the gamepad navigation key repeater.
// ----------------------------------------------------------------------------
package gnkr_pkg;

   typedef logic [2:0] dir_type;
   localparam dir_type DIR_NONE  = 3'd0;
   localparam dir_type DIR_UP    = 3'd1;
   localparam dir_type DIR_DOWN  = 3'd2;
   localparam dir_type DIR_LEFT  = 3'd3;
   localparam dir_type DIR_RIGHT = 3'd4;

   typedef logic [1:0] op_type;
   localparam op_type OP_PRESS   = 2'd0;
   localparam op_type OP_RELEASE = 2'd1;
   localparam op_type OP_POLL    = 2'd2;
   localparam op_type OP_RESUME  = 2'd3;

   typedef logic [3:0] btn_type;
   localparam btn_type BTN_A     = 4'd0;
   localparam btn_type BTN_B     = 4'd1;
   localparam btn_type BTN_X     = 4'd2;
   localparam btn_type BTN_Y     = 4'd3;
   localparam btn_type BTN_START = 4'd4;
   localparam btn_type BTN_UP    = 4'd5;
   localparam btn_type BTN_DOWN  = 4'd6;
   localparam btn_type BTN_LEFT  = 4'd7;
   localparam btn_type BTN_RIGHT = 4'd8;

   typedef logic [3:0] key_type;
   localparam key_type KC_UP     = 4'd0;
   localparam key_type KC_DOWN   = 4'd1;
   localparam key_type KC_LEFT   = 4'd2;
   localparam key_type KC_RIGHT  = 4'd3;
   localparam key_type KC_TAB    = 4'd4;
   localparam key_type KC_SPACE  = 4'd5;
   localparam key_type KC_ENTER  = 4'd6;
   localparam key_type KC_ESC    = 4'd7;
   localparam key_type KC_MENU   = 4'd8;
   localparam key_type KC_HANGUP = 4'd9;

   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_UI_NAV_MODE   = 3'd0;
   localparam reg_idx_type REG_SWAP_FACE     = 3'd1;
   localparam reg_idx_type REG_PRESS_THR     = 3'd2;
   localparam reg_idx_type REG_RELEASE_THR   = 3'd3;
   localparam reg_idx_type REG_INIT_DELAY    = 3'd4;
   localparam reg_idx_type REG_START_IVL     = 3'd5;
   localparam reg_idx_type REG_MIN_IVL       = 3'd6;
   localparam reg_idx_type REG_IVL_STEP      = 3'd7;

   localparam logic [14:0] PRESS_THR_RST   = 15'd20000;
   localparam logic [14:0] RELEASE_THR_RST = 15'd12000;
   localparam logic [15:0] INIT_DELAY_RST  = 16'd400;
   localparam logic [15:0] START_IVL_RST   = 16'd100;
   localparam logic [15:0] MIN_IVL_RST     = 16'd50;
   localparam logic [15:0] IVL_STEP_RST    = 16'd10;

   localparam int MAX_PADS    = 4;
   localparam int QDEPTH      = 4;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);
   localparam int QIDX_W      = $clog2(QDEPTH);
   localparam int REQ_DATA_W  = 168;
   localparam int RSP_DATA_W  = 8;
   localparam int PAD_BASE    = 40;
   localparam int PAD_STRIDE  = 32;

   // What one stick lane found for its pad.
   typedef struct packed {
      logic    keep;   // the held stick direction is still beyond release
      dir_type dir;    // direction past the press threshold, or none
   } lane_type;

   // One result item.
   typedef struct packed {
      key_type key_code;
      logic    shift_mod;
      logic    is_release;
      logic    auto_repeat;
      logic    last_of_run;
   } rsp_type;

   typedef struct packed {
      key_type key_code;
      logic    shift_mod;
   } keyshift_type;

   // Key and modifier sent for a direction.
   function automatic keyshift_type dir_key(input dir_type dir, input logic ui_nav);
      keyshift_type ks;
      ks.shift_mod = 1'b0;
      ks.key_code  = KC_UP;
      case (dir)
         DIR_UP: begin
            ks.key_code  = ui_nav ? KC_TAB : KC_UP;
            ks.shift_mod = ui_nav;
         end
         DIR_DOWN:  ks.key_code = ui_nav ? KC_TAB : KC_DOWN;
         DIR_LEFT:  ks.key_code = KC_LEFT;
         DIR_RIGHT: ks.key_code = KC_RIGHT;
         default:   ks.key_code = KC_UP;
      endcase
      return ks;
   endfunction

endpackage

// File: design/gnkr_stick_lane.sv
// ----------------------------------------------------------------------------
// gnkr_stick_lane
// Qualifies one pad's left stick: dominant axis, press threshold, and the
// lower release threshold for a direction already held by stick.
// ----------------------------------------------------------------------------
module gnkr_stick_lane (
   input  logic signed [15:0]  pad_x,
   input  logic signed [15:0]  pad_y,
   input  logic [14:0]         press_thr,
   input  logic [14:0]         release_thr,
   input  gnkr_pkg::dir_type   held_dir,
   input  logic                held_by_stick,
   output gnkr_pkg::lane_type  lane_res
);

   logic signed [16:0] xs;
   logic signed [16:0] ys;
   logic signed [16:0] ax;
   logic signed [16:0] ay;
   logic signed [16:0] prs;
   logic signed [16:0] rls;
   logic               keep_hit;

   assign xs  = {pad_x[15], pad_x};
   assign ys  = {pad_y[15], pad_y};
   assign ax  = xs[16] ? -xs : xs;
   assign ay  = ys[16] ? -ys : ys;
   assign prs = {2'b00, press_thr};
   assign rls = {2'b00, release_thr};

   always_comb begin
      keep_hit = 1'b0;
      case (held_dir)
         gnkr_pkg::DIR_UP:    keep_hit = ys < -rls;
         gnkr_pkg::DIR_DOWN:  keep_hit = ys > rls;
         gnkr_pkg::DIR_LEFT:  keep_hit = xs < -rls;
         gnkr_pkg::DIR_RIGHT: keep_hit = xs > rls;
         default:             keep_hit = 1'b0;
      endcase
   end

   always_comb begin
      lane_res.keep = held_by_stick && keep_hit;
      lane_res.dir  = gnkr_pkg::DIR_NONE;
      if (ay >= ax) begin
         if (ys < -prs) begin
            lane_res.dir = gnkr_pkg::DIR_UP;
         end else if (ys > prs) begin
            lane_res.dir = gnkr_pkg::DIR_DOWN;
         end
      end else begin
         if (xs < -prs) begin
            lane_res.dir = gnkr_pkg::DIR_LEFT;
         end else if (xs > prs) begin
            lane_res.dir = gnkr_pkg::DIR_RIGHT;
         end
      end
   end

endmodule

// File: design/gnkr_rsp_queue.sv
// ----------------------------------------------------------------------------
// gnkr_rsp_queue
// Small shifting result queue: takes up to two items per cycle from the
// control logic and hands one per cycle to the result channel while it is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gnkr_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,
   input  gnkr_pkg::rsp_type push_0,
   input  gnkr_pkg::rsp_type push_1,
   output logic              has_room,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output gnkr_pkg::rsp_type rsp_head
);

   gnkr_pkg::rsp_type                  q_ff [gnkr_pkg::QDEPTH];
   gnkr_pkg::rsp_type                  q_in [gnkr_pkg::QDEPTH];
   logic [gnkr_pkg::QCNT_W-1:0]        cnt_ff;
   logic [gnkr_pkg::QCNT_W-1:0]        cnt_in;
   logic [gnkr_pkg::QCNT_W-1:0]        cnt_kept;
   logic [gnkr_pkg::QIDX_W-1:0]        widx0;
   logic [gnkr_pkg::QIDX_W-1:0]        widx1;
   logic                               pop;

   // Room for a full pair is kept whenever an item is taken.
   assign has_room   = cnt_ff <= gnkr_pkg::QCNT_W'(gnkr_pkg::QDEPTH - 2);
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_head   = q_ff[0];
   assign pop        = rsp_tvalid && rsp_tready;
   assign cnt_kept   = cnt_ff - gnkr_pkg::QCNT_W'(pop);
   assign widx0      = cnt_kept[gnkr_pkg::QIDX_W-1:0];
   assign widx1      = widx0 + gnkr_pkg::QIDX_W'(1);
   assign cnt_in     = cnt_kept + gnkr_pkg::QCNT_W'(push_n);

   always_comb begin
      for (int i = 0; i < gnkr_pkg::QDEPTH - 1; i++) begin
         if (pop) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      q_in[gnkr_pkg::QDEPTH - 1] = q_ff[gnkr_pkg::QDEPTH - 1];
      if (push_n != 2'd0) begin
         q_in[widx0] = push_0;
      end
      if (push_n == 2'd2) begin
         q_in[widx1] = push_1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   `GNKR_ASSERT(a_cnt_bound, cnt_ff <= gnkr_pkg::QCNT_W'(gnkr_pkg::QDEPTH), "queue overfilled")
   `GNKR_ASSERT_IMPL(a_push_room, push_n != 2'd0, has_room, "push into a full queue")

endmodule

// File: design/gamepad_nav_key_repeater_core.sv
// ----------------------------------------------------------------------------
// gamepad_nav_key_repeater_core
// Gamepad button events and polls in, navigation key events out.
// ----------------------------------------------------------------------------
// Input items arrive on req_: tuser carries the operation (press, release,
// poll, resume), tdata the button, time, D-pad mask and stick samples.
// Result items leave on rsp_ with tlast on the final result of an item.
// Registers are written through csr_ (always ready); the user must write them
// only while the block is idle, which the block itself does not enforce.
// One stick lane per pad qualifies its stick in parallel; a merge stage picks
// the first pad that keeps or starts a direction. A four-entry result queue
// decouples the two sides; results leave on rsp_ one per cycle while the
// receiver is ready, and req_tready is high while at least two entries are
// free, so items with at most one result flow at one per cycle, and items
// with a key pair are limited by the result channel.
// A stalled receiver just fills the queue and then holds req_tready low.
// Reset empties the queue, clears the held direction and repeat state and
// loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gamepad_nav_key_repeater_core #(
   parameter int NUM_PADS = 4
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: button[3:0], now_ms[35:4], dpad_held[39:36], pad0_x[55:40],
   // pad0_y[71:56], pad1_x[87:72], pad1_y[103:88], pad2_x[119:104],
   // pad2_y[135:120], pad3_x[151:136], pad3_y[167:152]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,
   input  logic [1:0]   req_tuser,   // operation[1:0]
   // rsp_tdata: key_code[3:0], shift_mod[4], is_release[5], auto_repeat[6], zero[7]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast,   // last_of_run
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // Configuration registers.
   logic        ui_nav_ff;
   logic        swap_face_ff;
   logic [14:0] press_thr_ff;
   logic [14:0] release_thr_ff;
   logic [15:0] init_delay_ff;
   logic [15:0] start_ivl_ff;
   logic [15:0] min_ivl_ff;
   logic [15:0] ivl_step_ff;

   // Hold and repeat state.
   gnkr_pkg::dir_type held_dir_ff, held_dir_in;
   logic              held_dpad_ff, held_dpad_in;
   logic [31:0]       hold_start_ff, hold_start_in;
   logic [31:0]       last_rep_ff, last_rep_in;
   logic [7:0]        rep_cnt_ff, rep_cnt_in;

   logic                 req_accept;
   gnkr_pkg::op_type     op;
   gnkr_pkg::btn_type    btn;
   gnkr_pkg::btn_type    btn_eff;
   logic [31:0]          now_ms;
   logic [3:0]           dpad_held;
   logic                 held_by_stick;
   gnkr_pkg::lane_type   lane_res [NUM_PADS];
   gnkr_pkg::dir_type    stick_dir;
   logic                 stick_found;
   gnkr_pkg::dir_type    held_eff;
   gnkr_pkg::dir_type    send_dir;
   gnkr_pkg::keyshift_type send_ks;
   logic                 send_pair;
   logic                 send_rep;
   logic                 go_repeat;
   logic [1:0]           dpad_bit;
   logic [23:0]          step_prod;
   logic signed [25:0]   ivl_raw;
   logic [15:0]          ivl_eff;
   logic [31:0]          since_hold;
   logic [31:0]          since_rep;
   logic [1:0]           push_n;
   gnkr_pkg::rsp_type    push_0;
   gnkr_pkg::rsp_type    push_1;
   logic                 has_room;
   gnkr_pkg::rsp_type    rsp_head;

   assign op        = req_tuser;
   assign btn       = req_tdata[3:0];
   assign now_ms    = req_tdata[35:4];
   assign dpad_held = req_tdata[39:36];
   assign req_tready = has_room;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- lanes
   assign held_by_stick = (held_dir_ff != gnkr_pkg::DIR_NONE) && !held_dpad_ff;

   for (genvar p = 0; p < NUM_PADS; p++) begin : g_lane
      gnkr_stick_lane u_lane (
         .pad_x         (req_tdata[gnkr_pkg::PAD_BASE + gnkr_pkg::PAD_STRIDE*p +: 16]),
         .pad_y         (req_tdata[gnkr_pkg::PAD_BASE + gnkr_pkg::PAD_STRIDE*p + 16 +: 16]),
         .press_thr     (press_thr_ff),
         .release_thr   (release_thr_ff),
         .held_dir      (held_dir_ff),
         .held_by_stick (held_by_stick),
         .lane_res      (lane_res[p])
      );
   end

   // The first pad that keeps the held direction or starts one wins.
   always_comb begin
      stick_dir   = gnkr_pkg::DIR_NONE;
      stick_found = 1'b0;
      for (int p = 0; p < NUM_PADS; p++) begin
         if (!stick_found) begin
            if (lane_res[p].keep) begin
               stick_dir   = held_dir_ff;
               stick_found = 1'b1;
            end else if (lane_res[p].dir != gnkr_pkg::DIR_NONE) begin
               stick_dir   = lane_res[p].dir;
               stick_found = 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------- repeat timing
   assign dpad_bit   = 2'(held_dir_ff - gnkr_pkg::dir_type'(1));
   assign step_prod  = rep_cnt_ff * ivl_step_ff;
   assign ivl_raw    = $signed({10'b0, start_ivl_ff}) - $signed({2'b0, step_prod});
   assign ivl_eff    = (ivl_raw < $signed({10'b0, min_ivl_ff})) ? min_ivl_ff : ivl_raw[15:0];
   assign since_hold = now_ms - hold_start_ff;
   assign since_rep  = now_ms - last_rep_ff;
   assign btn_eff    = (swap_face_ff && (btn <= gnkr_pkg::BTN_Y)) ? (btn ^ 4'd1) : btn;

   // ------------------------------------------------------ item handling
   always_comb begin
      held_dir_in   = held_dir_ff;
      held_dpad_in  = held_dpad_ff;
      hold_start_in = hold_start_ff;
      last_rep_in   = last_rep_ff;
      rep_cnt_in    = rep_cnt_ff;
      held_eff      = held_dir_ff;
      go_repeat     = 1'b0;
      send_pair     = 1'b0;
      send_rep      = 1'b0;
      send_dir      = gnkr_pkg::DIR_NONE;
      push_n        = 2'd0;
      push_0        = '0;
      if (req_accept) begin
         case (op)
            gnkr_pkg::OP_RESUME: begin
               held_dir_in = gnkr_pkg::DIR_NONE;
            end
            gnkr_pkg::OP_POLL: begin
               // A D-pad hold ends once its bit drops out of the mask.
               if ((held_dir_ff != gnkr_pkg::DIR_NONE) && held_dpad_ff &&
                   !dpad_held[dpad_bit]) begin
                  held_eff = gnkr_pkg::DIR_NONE;
               end
               held_dir_in = held_eff;
               go_repeat   = 1'b1;
               if (((held_eff == gnkr_pkg::DIR_NONE) || !held_dpad_ff) &&
                   (stick_dir != held_eff)) begin
                  go_repeat = 1'b0;
                  if (stick_dir == gnkr_pkg::DIR_NONE) begin
                     held_dir_in = gnkr_pkg::DIR_NONE;
                  end else begin
                     send_pair     = 1'b1;
                     send_dir      = stick_dir;
                     held_dir_in   = stick_dir;
                     held_dpad_in  = 1'b0;
                     hold_start_in = now_ms;
                     last_rep_in   = now_ms;
                     rep_cnt_in    = '0;
                  end
               end
               if (go_repeat && (held_eff != gnkr_pkg::DIR_NONE) &&
                   (since_hold >= {16'b0, init_delay_ff}) &&
                   (since_rep >= {16'b0, ivl_eff})) begin
                  send_pair   = 1'b1;
                  send_rep    = 1'b1;
                  send_dir    = held_eff;
                  last_rep_in = now_ms;
                  if (rep_cnt_ff != 8'hFF) begin
                     rep_cnt_in = rep_cnt_ff + 8'd1;
                  end
               end
            end
            default: begin
               push_0.is_release  = op[0];
               push_0.last_of_run = 1'b1;
               case (btn_eff)
                  gnkr_pkg::BTN_UP, gnkr_pkg::BTN_DOWN,
                  gnkr_pkg::BTN_LEFT, gnkr_pkg::BTN_RIGHT: begin
                     if (op == gnkr_pkg::OP_PRESS) begin
                        send_pair     = 1'b1;
                        send_dir      = 3'(btn_eff - 4'd4);
                        held_dir_in   = 3'(btn_eff - 4'd4);
                        held_dpad_in  = 1'b1;
                        hold_start_in = now_ms;
                        last_rep_in   = now_ms;
                        rep_cnt_in    = '0;
                     end
                  end
                  gnkr_pkg::BTN_A: begin
                     push_0.key_code = ui_nav_ff ? gnkr_pkg::KC_SPACE : gnkr_pkg::KC_ENTER;
                     push_n = 2'd1;
                  end
                  gnkr_pkg::BTN_B: begin
                     push_0.key_code = gnkr_pkg::KC_ESC;
                     push_n = 2'd1;
                  end
                  gnkr_pkg::BTN_X: begin
                     push_0.key_code = gnkr_pkg::KC_MENU;
                     push_n = 2'd1;
                  end
                  gnkr_pkg::BTN_Y, gnkr_pkg::BTN_START: begin
                     push_0.key_code = gnkr_pkg::KC_HANGUP;
                     push_n = 2'd1;
                  end
                  default: push_n = 2'd0;
               endcase
            end
         endcase
         // A direction key goes out as a press followed by a release.
         if (send_pair) begin
            push_n             = 2'd2;
            push_0.key_code    = send_ks.key_code;
            push_0.shift_mod   = send_ks.shift_mod;
            push_0.is_release  = 1'b0;
            push_0.auto_repeat = send_rep;
            push_0.last_of_run = 1'b0;
         end
      end
   end

   assign send_ks = gnkr_pkg::dir_key(send_dir, ui_nav_ff);

   always_comb begin
      push_1             = push_0;
      push_1.is_release  = 1'b1;
      push_1.last_of_run = 1'b1;
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_dir_ff   <= gnkr_pkg::DIR_NONE;
         held_dpad_ff  <= 1'b0;
         hold_start_ff <= '0;
         last_rep_ff   <= '0;
         rep_cnt_ff    <= '0;
      end else begin
         held_dir_ff   <= held_dir_in;
         held_dpad_ff  <= held_dpad_in;
         hold_start_ff <= hold_start_in;
         last_rep_ff   <= last_rep_in;
         rep_cnt_ff    <= rep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ui_nav_ff      <= 1'b0;
         swap_face_ff   <= 1'b0;
         press_thr_ff   <= gnkr_pkg::PRESS_THR_RST;
         release_thr_ff <= gnkr_pkg::RELEASE_THR_RST;
         init_delay_ff  <= gnkr_pkg::INIT_DELAY_RST;
         start_ivl_ff   <= gnkr_pkg::START_IVL_RST;
         min_ivl_ff     <= gnkr_pkg::MIN_IVL_RST;
         ivl_step_ff    <= gnkr_pkg::IVL_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gnkr_pkg::REG_UI_NAV_MODE: ui_nav_ff      <= csr_wdata[0];
            gnkr_pkg::REG_SWAP_FACE:   swap_face_ff   <= csr_wdata[0];
            gnkr_pkg::REG_PRESS_THR:   press_thr_ff   <= csr_wdata[14:0];
            gnkr_pkg::REG_RELEASE_THR: release_thr_ff <= csr_wdata[14:0];
            gnkr_pkg::REG_INIT_DELAY:  init_delay_ff  <= csr_wdata;
            gnkr_pkg::REG_START_IVL:   start_ivl_ff   <= csr_wdata;
            gnkr_pkg::REG_MIN_IVL:     min_ivl_ff     <= csr_wdata;
            gnkr_pkg::REG_IVL_STEP:    ivl_step_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- result queue
   gnkr_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push_0     (push_0),
      .push_1     (push_1),
      .has_room   (has_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (rsp_head)
   );

   assign rsp_tdata = {1'b0, rsp_head.auto_repeat, rsp_head.is_release,
                       rsp_head.shift_mod, rsp_head.key_code};
   assign rsp_tlast = rsp_head.last_of_run;

   `GNKR_ASSERT(a_held_range, held_dir_ff <= gnkr_pkg::DIR_RIGHT, "held direction out of range")
   `GNKR_ASSERT_IMPL(a_rep_cnt_step, rep_cnt_ff != $past(rep_cnt_ff),
      (rep_cnt_ff == $past(rep_cnt_ff) + 8'd1) || (rep_cnt_ff == 8'd0),
      "repeat count moved other than by one or to zero")
   `GNKR_ASSERT_IMPL(a_no_push_idle, !req_accept, push_n == 2'd0,
      "results pushed without an accepted item")

endmodule
